// ----- hw/rtl/x10chs_pkg.sv -----
package x10chs_pkg;

   // Field widths
   localparam int unsigned OP_W    = 2;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned PCT_W   = 7;
   localparam int unsigned DIM_W   = 5;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned EV_W    = 3;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned PROD_W  = PCT_W + DIM_W;
   localparam int unsigned CSR_AW  = 3;
   localparam int unsigned REQ_DW  = 32;
   localparam int unsigned REQ_UW  = OP_W;
   localparam int unsigned RSP_DW  = BYTE_W;
   localparam int unsigned RSP_UW  = 1 + EV_W;

   // Beats per request item at most
   localparam int unsigned MAX_RES = 3;
   localparam int unsigned CNT_W   = 2;

   // Percent clamp and divide by 100 as multiply by reciprocal
   localparam logic [PCT_W-1:0] PCT_MAX      = 7'd100;
   localparam int unsigned      DIV100_MUL_W = 13;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
   localparam int unsigned      DIV100_SHIFT = 19;
   localparam int unsigned      QPROD_W      = PROD_W + DIV100_MUL_W;

   // Opcodes
   localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
   localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd1;
   localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

   // Event codes
   localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
   localparam logic [EV_W-1:0] EV_BUSY      = 3'd1;
   localparam logic [EV_W-1:0] EV_ADDR_OK   = 3'd2;
   localparam logic [EV_W-1:0] EV_ADDR_FAIL = 3'd3;
   localparam logic [EV_W-1:0] EV_FUNC_OK   = 3'd4;
   localparam logic [EV_W-1:0] EV_FUNC_FAIL = 3'd5;

   // Phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ADDR_SUM   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ADDR_READY = 3'd2;
   localparam logic [PHASE_W-1:0] PH_FUNC_SUM   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_FUNC_READY = 3'd4;

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_RETRY_LIMIT   = 3'd0;
   localparam logic [CSR_AW-1:0] REG_MAX_DIM       = 3'd1;
   localparam logic [CSR_AW-1:0] REG_ADDR_HEADER   = 3'd2;
   localparam logic [CSR_AW-1:0] REG_FUNC_HDR_BITS = 3'd3;
   localparam logic [CSR_AW-1:0] REG_ACK_BYTE      = 3'd4;
   localparam logic [CSR_AW-1:0] REG_READY_BYTE    = 3'd5;

   // Register reset values
   localparam logic [CODE_W-1:0] RST_RETRY_LIMIT   = 4'd10;
   localparam logic [DIM_W-1:0]  RST_MAX_DIM       = 5'd22;
   localparam logic [BYTE_W-1:0] RST_ADDR_HEADER   = 8'd4;
   localparam logic [2:0]        RST_FUNC_HDR_BITS = 3'd6;
   localparam logic [BYTE_W-1:0] RST_ACK_BYTE      = 8'd0;
   localparam logic [BYTE_W-1:0] RST_READY_BYTE    = 8'd85;

   // One result beat
   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_valid;
      logic [EV_W-1:0]   event_res;
   } res_type;

   function automatic res_type tx_beat(input logic [BYTE_W-1:0] b);
      res_type r;
      r.tx_byte   = b;
      r.tx_valid  = 1'b1;
      r.event_res = EV_NONE;
      return r;
   endfunction

   function automatic res_type ev_beat(input logic [EV_W-1:0] ev);
      res_type r;
      r.tx_byte   = '0;
      r.tx_valid  = 1'b0;
      r.event_res = ev;
      return r;
   endfunction

endpackage

// ----- hw/rtl/x10_command_handshake_sender_core.sv -----
// Command handshake sender: each accepted request beat yields zero to three
// result beats. A new request sends the two-byte address packet; echoes of the
// packet checksum, the ready byte and read timeouts (all given as request
// beats) advance the handshake, which then sends the two-byte function packet
// with the dim level. Failed packets are resent until retry_limit attempts are
// used. One request beat is taken every cycle as long as the result buffer can
// drain; a beat that produces N results holds the result port until all N are
// taken, and the next request beat is not processed until then. A request
// reaches its first result beat through the input register and the result
// register. Requests while a handshake is running get a busy reject result.
module x10_command_handshake_sender_core (
   input  logic                             clock,
   input  logic                             reset,
   // Config write port
   input  logic                             csr_we,
   input  logic [x10chs_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [x10chs_pkg::BYTE_W-1:0]    csr_wdata,
   // Request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: house_code[3:0], device_code[7:4], function_code[11:8],
   //        dim_percent[18:12], rx_byte[26:19], zero[31:27]
   input  logic [x10chs_pkg::REQ_DW-1:0]    req_tdata,
   // tuser: opcode[1:0]
   input  logic [x10chs_pkg::REQ_UW-1:0]    req_tuser,
   // Result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: tx_byte[7:0]
   output logic [x10chs_pkg::RSP_DW-1:0]    rsp_tdata,
   // tuser: tx_valid[0], event_res[3:1]
   output logic [x10chs_pkg::RSP_UW-1:0]    rsp_tuser,
   output logic                             rsp_tlast
);
   import x10chs_pkg::*;

   // Config registers
   logic [CODE_W-1:0] retry_limit_ff;
   logic [DIM_W-1:0]  max_dim_ff;
   logic [BYTE_W-1:0] addr_header_ff;
   logic [2:0]        func_hdr_bits_ff;
   logic [BYTE_W-1:0] ack_byte_ff;
   logic [BYTE_W-1:0] ready_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff   <= RST_RETRY_LIMIT;
         max_dim_ff       <= RST_MAX_DIM;
         addr_header_ff   <= RST_ADDR_HEADER;
         func_hdr_bits_ff <= RST_FUNC_HDR_BITS;
         ack_byte_ff      <= RST_ACK_BYTE;
         ready_byte_ff    <= RST_READY_BYTE;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_RETRY_LIMIT:   retry_limit_ff   <= csr_wdata[CODE_W-1:0];
            REG_MAX_DIM:       max_dim_ff       <= csr_wdata[DIM_W-1:0];
            REG_ADDR_HEADER:   addr_header_ff   <= csr_wdata;
            REG_FUNC_HDR_BITS: func_hdr_bits_ff <= csr_wdata[2:0];
            REG_ACK_BYTE:      ack_byte_ff      <= csr_wdata;
            REG_READY_BYTE:    ready_byte_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request field unpack
   logic [OP_W-1:0]   req_opcode;
   logic [CODE_W-1:0] req_house;
   logic [CODE_W-1:0] req_device;
   logic [CODE_W-1:0] req_function;
   logic [PCT_W-1:0]  req_pct;
   logic [BYTE_W-1:0] req_rx;
   logic [PCT_W-1:0]  pct_clamped;

   assign req_opcode   = req_tuser;
   assign req_house    = req_tdata[3:0];
   assign req_device   = req_tdata[7:4];
   assign req_function = req_tdata[11:8];
   assign req_pct      = req_tdata[18:12];
   assign req_rx       = req_tdata[26:19];
   assign pct_clamped  = (req_pct > PCT_MAX) ? PCT_MAX : req_pct;

   // Input register; the percent times max level product is formed on capture
   logic              in_valid_ff;
   logic [OP_W-1:0]   in_op_ff;
   logic [CODE_W-1:0] in_house_ff;
   logic [CODE_W-1:0] in_device_ff;
   logic [CODE_W-1:0] in_function_ff;
   logic [PROD_W-1:0] in_prod_ff;
   logic [BYTE_W-1:0] in_rx_ff;
   logic              fire;
   logic              req_take;

   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff       <= req_opcode;
         in_house_ff    <= req_house;
         in_device_ff   <= req_device;
         in_function_ff <= req_function;
         in_prod_ff     <= PROD_W'(pct_clamped) * PROD_W'(max_dim_ff);
         in_rx_ff       <= req_rx;
      end
   end

   // Handshake state
   logic [PHASE_W-1:0] phase_ff,    phase_in;
   logic [CODE_W-1:0]  attempt_ff,  attempt_in;
   logic [CODE_W-1:0]  house_ff,    house_in;
   logic [CODE_W-1:0]  device_ff,   device_in;
   logic [CODE_W-1:0]  function_ff, function_in;
   logic [DIM_W-1:0]   dim_ff,      dim_in;
   logic [BYTE_W-1:0]  sum_ff,      sum_in;

   // Dim level: product / 100 by reciprocal multiply
   logic [QPROD_W-1:0] dim_q;
   assign dim_q = QPROD_W'(in_prod_ff) * QPROD_W'(DIV100_MUL);

   // Packet bytes, built from the held values after this beat's update
   logic [PHASE_W-1:0] ph;
   logic               new_req;
   logic [BYTE_W-1:0]  addr_lo, func_hi, func_lo, addr_sum, func_sum;
   logic [CODE_W-1:0]  att_inc;
   logic               retry_ok;
   logic               good_rx;
   logic               do_fail;
   logic               fail_addr;
   res_type            res [MAX_RES];
   logic [CNT_W-1:0]   n_res;

   assign ph      = (phase_ff > PH_FUNC_READY) ? PH_IDLE : phase_ff;
   assign new_req = (in_op_ff == OP_REQUEST) && (ph == PH_IDLE);

   assign house_in    = new_req ? in_house_ff    : house_ff;
   assign device_in   = new_req ? in_device_ff   : device_ff;
   assign function_in = new_req ? in_function_ff : function_ff;
   assign dim_in      = new_req ? dim_q[DIV100_SHIFT +: DIM_W] : dim_ff;

   assign addr_lo  = {house_in, device_in};
   assign func_hi  = {dim_in, func_hdr_bits_ff};
   assign func_lo  = {house_in, function_in};
   assign addr_sum = addr_header_ff + addr_lo;
   assign func_sum = func_hi + func_lo;

   assign att_inc  = attempt_ff + CODE_W'(1);
   assign retry_ok = (att_inc != '0) && (att_inc <= retry_limit_ff)
                     && (retry_limit_ff > CODE_W'(1));
   assign good_rx  = (in_op_ff == OP_RX_BYTE);

   // Next state and result beats for the registered request beat
   always_comb begin
      phase_in   = ph;
      attempt_in = attempt_ff;
      sum_in     = sum_ff;
      do_fail    = 1'b0;
      fail_addr  = 1'b0;
      n_res      = '0;
      for (int i = 0; i < MAX_RES; i++) begin
         res[i] = ev_beat(EV_NONE);
      end

      if (in_op_ff == OP_REQUEST) begin
         if (ph != PH_IDLE) begin
            res[0] = ev_beat(EV_BUSY);
            n_res  = CNT_W'(1);
         end else begin
            attempt_in = CODE_W'(1);
            phase_in   = PH_ADDR_SUM;
            sum_in     = addr_sum;
            res[0]     = tx_beat(addr_header_ff);
            res[1]     = tx_beat(addr_lo);
            n_res      = CNT_W'(2);
         end
      end else if ((in_op_ff == OP_RX_BYTE) || (in_op_ff == OP_TIMEOUT)) begin
         unique case (ph)
            PH_ADDR_SUM, PH_FUNC_SUM: begin
               if (good_rx && (in_rx_ff == sum_ff)) begin
                  phase_in = ph + PHASE_W'(1);
                  res[0]   = tx_beat(ack_byte_ff);
                  n_res    = CNT_W'(1);
               end else begin
                  do_fail   = 1'b1;
                  fail_addr = (ph == PH_ADDR_SUM);
               end
            end
            PH_ADDR_READY: begin
               if (good_rx && (in_rx_ff == ready_byte_ff)) begin
                  attempt_in = CODE_W'(1);
                  phase_in   = PH_FUNC_SUM;
                  sum_in     = func_sum;
                  res[0]     = ev_beat(EV_ADDR_OK);
                  res[1]     = tx_beat(func_hi);
                  res[2]     = tx_beat(func_lo);
                  n_res      = CNT_W'(3);
               end else begin
                  do_fail   = 1'b1;
                  fail_addr = 1'b1;
               end
            end
            PH_FUNC_READY: begin
               if (good_rx && (in_rx_ff == ready_byte_ff)) begin
                  attempt_in = '0;
                  phase_in   = PH_IDLE;
                  res[0]     = ev_beat(EV_FUNC_OK);
                  n_res      = CNT_W'(1);
               end else begin
                  do_fail = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // Failed packet: resend, or give up on it
      if (do_fail) begin
         attempt_in = att_inc;
         if (retry_ok) begin
            phase_in = fail_addr ? PH_ADDR_SUM : PH_FUNC_SUM;
            sum_in   = fail_addr ? addr_sum : func_sum;
            res[0]   = tx_beat(fail_addr ? addr_header_ff : func_hi);
            res[1]   = tx_beat(fail_addr ? addr_lo : func_lo);
            n_res    = CNT_W'(2);
         end else if (fail_addr) begin
            // address given up, function packet still goes out
            attempt_in = CODE_W'(1);
            phase_in   = PH_FUNC_SUM;
            sum_in     = func_sum;
            res[0]     = ev_beat(EV_ADDR_FAIL);
            res[1]     = tx_beat(func_hi);
            res[2]     = tx_beat(func_lo);
            n_res      = CNT_W'(3);
         end else begin
            attempt_in = '0;
            phase_in   = PH_IDLE;
            res[0]     = ev_beat(EV_FUNC_FAIL);
            n_res      = CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         attempt_ff  <= '0;
         house_ff    <= '0;
         device_ff   <= '0;
         function_ff <= '0;
         dim_ff      <= '0;
         sum_ff      <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         attempt_ff  <= attempt_in;
         house_ff    <= house_in;
         device_ff   <= device_in;
         function_ff <= function_in;
         dim_ff      <= dim_in;
         sum_ff      <= sum_in;
      end
   end

   // Result buffer: holds the beats of one request, drained one per cycle while rsp_tready is high
   res_type          buf_ff [MAX_RES];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             rsp_take;
   logic             buf_last;
   logic             buf_free;

   assign rsp_tvalid = (cnt_ff != '0);
   assign buf_last   = (idx_ff + CNT_W'(1)) == cnt_ff;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign buf_free   = !rsp_tvalid || (rsp_take && buf_last);
   assign fire       = in_valid_ff && buf_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (fire) begin
         cnt_ff <= n_res;
         idx_ff <= '0;
      end else if (rsp_take) begin
         if (buf_last) begin
            cnt_ff <= '0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < MAX_RES; i++) begin
            buf_ff[i] <= res[i];
         end
      end
   end

   assign rsp_tdata = buf_ff[idx_ff].tx_byte;
   assign rsp_tuser = {buf_ff[idx_ff].event_res, buf_ff[idx_ff].tx_valid};
   assign rsp_tlast = buf_last;

   // Checks
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (idx_ff < cnt_ff))
      else $error("result index beyond beat count");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_FUNC_READY)
      else $error("phase register holds an unused code");

   a_idle_no_attempts: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (attempt_ff == '0))
      else $error("attempt count left over in idle");

   a_tx_no_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tuser[3:1] == EV_NONE))
      else $error("transmit beat carries an event");

endmodule
